FILE: rtl/dna_kmer_rolling_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// DNA k-mer encoder assertion macros
// Concurrent assertion wrappers for the encoder checker.
// ----------------------------------------------------------------------------
`ifndef DNA_KMER_ROLLING_ENCODER_UNIT_DEFINES_SVH
`define DNA_KMER_ROLLING_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define DNAKMER_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DNAKMER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dnakmer_pkg.sv
// ----------------------------------------------------------------------------
// DNA k-mer encoder package
// Character constants, widths and the nucleotide decode function.
// ----------------------------------------------------------------------------
package dnakmer_pkg;

    localparam int unsigned MAX_NT   = 32;
    localparam int unsigned CODE_W   = 2 * MAX_NT;
    localparam int unsigned K_W      = 6;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned SYM_W    = 8;

    localparam logic [K_W-1:0]   K_RESET = 6'd31;
    localparam logic [K_W-1:0]   K_MIN   = 6'd1;
    localparam logic [K_W-1:0]   K_MAX   = 6'd32;
    localparam logic [CNT_W-1:0] CNT_MAX = 6'd32;

    localparam logic [SYM_W-1:0] CH_A_UP = 8'h41;
    localparam logic [SYM_W-1:0] CH_C_UP = 8'h43;
    localparam logic [SYM_W-1:0] CH_G_UP = 8'h47;
    localparam logic [SYM_W-1:0] CH_T_UP = 8'h54;
    localparam logic [SYM_W-1:0] CH_A_LO = 8'h61;
    localparam logic [SYM_W-1:0] CH_C_LO = 8'h63;
    localparam logic [SYM_W-1:0] CH_G_LO = 8'h67;
    localparam logic [SYM_W-1:0] CH_T_LO = 8'h74;
    localparam logic [SYM_W-1:0] CH_LF   = 8'h0A;
    localparam logic [SYM_W-1:0] CH_CR   = 8'h0D;

    localparam logic [1:0] NT_A = 2'd0;
    localparam logic [1:0] NT_C = 2'd1;
    localparam logic [1:0] NT_G = 2'd2;
    localparam logic [1:0] NT_T = 2'd3;

    localparam logic ADDR_KMER_LENGTH = 1'b0;

    typedef struct packed {
        logic       is_break;
        logic       is_amb;
        logic [1:0] code;
    } t_nt_dec;

    function automatic t_nt_dec nt_decode(input logic [SYM_W-1:0] sym);
        t_nt_dec d;
        d = '{is_break: 1'b0, is_amb: 1'b0, code: NT_A};
        case (sym)
            CH_A_UP, CH_A_LO: d.code = NT_A;
            CH_C_UP, CH_C_LO: d.code = NT_C;
            CH_G_UP, CH_G_LO: d.code = NT_G;
            CH_T_UP, CH_T_LO: d.code = NT_T;
            CH_LF, CH_CR:     d.is_break = 1'b1;
            default:          d.is_amb = 1'b1;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/dna_kmer_rolling_encoder_unit.sv
// An accepted word waits in the input register; its k-mer word is then loaded into the output register.
// Throughput: one word per cycle while the output is not stalled; the window
// shift, decode and mask sit between the input register and the output register.
// Line breaks and words before k nucleotides give no output word.
// Reset (synchronous, active low) clears the window, count and valids,
// and sets kmer_length to 31.
// ----------------------------------------------------------------------------
// DNA k-mer rolling encoder
// Codes characters as 2-bit nucleotides, keeps a 32-position window with
// ambiguity marks and emits the masked k-mer once k nucleotides are loaded.
// ----------------------------------------------------------------------------
module dna_kmer_rolling_encoder_unit
    import dnakmer_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic                i_seq_start,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [CODE_W-1:0]   o_kmer_code,
    output logic                o_is_ambiguous,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [K_W-1:0]    r_kmer_length;

    logic              r_in_valid;
    logic [SYM_W-1:0]  r_symbol;
    logic              r_start;

    logic [CODE_W-1:0] r_window;
    logic [MAX_NT-1:0] r_ambig;
    logic [CNT_W-1:0]  r_count;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_kmer_code;
    logic              r_is_amb;

    logic              adv;
    t_nt_dec           dec;
    logic [CODE_W-1:0] base_window;
    logic [MAX_NT-1:0] base_ambig;
    logic [CNT_W-1:0]  base_count;
    logic [CODE_W-1:0] n_window;
    logic [MAX_NT-1:0] n_ambig;
    logic [CNT_W-1:0]  n_count;
    logic [K_W-1:0]    eff_k;
    logic [6:0]        kshift;
    logic [5:0]        ashift;
    logic [CODE_W-1:0] kmask;
    logic [MAX_NT-1:0] amask;
    logic              emit;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_KMER_LENGTH) ? {26'd0, r_kmer_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= K_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ADDR_KMER_LENGTH) begin
            r_kmer_length <= pwdata[K_W-1:0];
        end
    end

    // handshake
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_symbol <= i_symbol;
            r_start  <= i_seq_start;
        end
    end

    // window update
    always_comb begin
        dec         = nt_decode(r_symbol);
        base_window = r_start ? '0 : r_window;
        base_ambig  = r_start ? '0 : r_ambig;
        base_count  = r_start ? '0 : r_count;
        if (dec.is_break) begin
            n_window = base_window;
            n_ambig  = base_ambig;
            n_count  = base_count;
        end else begin
            n_window = {base_window[CODE_W-3:0], dec.code};
            n_ambig  = {base_ambig[MAX_NT-2:0], dec.is_amb};
            n_count  = (base_count < CNT_MAX) ? base_count + 6'd1 : base_count;
        end

        if (r_kmer_length < K_MIN) begin
            eff_k = K_MIN;
        end else if (r_kmer_length > K_MAX) begin
            eff_k = K_MAX;
        end else begin
            eff_k = r_kmer_length;
        end
        kshift = 7'd64 - {eff_k, 1'b0};
        ashift = 6'd32 - eff_k;
        kmask  = {CODE_W{1'b1}} >> kshift;
        amask  = {MAX_NT{1'b1}} >> ashift;
        emit   = !dec.is_break && (n_count >= eff_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_ambig  <= '0;
            r_count  <= '0;
        end else if (adv) begin
            r_window <= n_window;
            r_ambig  <= n_ambig;
            r_count  <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_kmer_code <= n_window & kmask;
            r_is_amb    <= |(n_ambig & amask);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kmer_code    = r_kmer_code;
    assign o_is_ambiguous = r_is_amb;

endmodule

FILE: rtl/dnakmer_chk.sv
// ----------------------------------------------------------------------------
// DNA k-mer encoder port checker
// Watches the top-level ports for stall, backpressure and reset behavior.
// ----------------------------------------------------------------------------
`include "dna_kmer_rolling_encoder_unit_defines.svh"

module dnakmer_chk
    import dnakmer_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_ready,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [CODE_W-1:0]   o_kmer_code,
    input  logic                o_is_ambiguous
);

    `DNAKMER_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kmer_code) && $stable(o_is_ambiguous), "output word changed while stalled")

    `DNAKMER_ASSERT_IMPL(a_bp_cause, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "input stalled without output backpressure")

    `DNAKMER_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !o_valid && o_ready, "not idle after reset")

endmodule

bind dna_kmer_rolling_encoder_unit dnakmer_chk u_dnakmer_chk (.*);
